>>> hw/rtl/ibhq_pkg.sv
// ----------------------------------------------------------------------------
// Indexed binary heap queue package
// Shared word types, codes, controller commands and the key compare.
// ----------------------------------------------------------------------------
package ibhq_pkg;

    // Default number of heap slots.
    localparam int CAPACITY = 64;
    // Key width, tag width and tag count follow from the fixed word formats.
    localparam int KEY_BITS = 32;
    localparam int TAG_BITS = 6;
    localparam int TAG_COUNT = 1 << TAG_BITS;
    localparam int POS_BITS = 7;

    typedef logic signed [KEY_BITS-1:0] key_t;
    typedef logic [TAG_BITS-1:0] tag_t;
    typedef logic [POS_BITS-1:0] pos_t;

    // Operation codes.
    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_UPDATE = 2'd2,
        OP_NONE   = 2'd3
    } op_e;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_NOTAG = 2'd3
    } status_e;

    // Request word.
    typedef struct packed {
        logic [1:0]  op;
        key_t        key;
        logic [31:0] payload;
        tag_t        tag;
    } req_t;

    // Result word.
    typedef struct packed {
        logic [1:0]  status;
        key_t        out_key;
        logic [31:0] out_payload;
        tag_t        out_tag;
        pos_t        final_position;
        pos_t        fill_count;
    } rsp_t;

    // One heap slot.
    typedef struct packed {
        key_t        key;
        logic [31:0] payload;
        tag_t        tag;
    } entry_t;

    // Commands from the controller to the datapath.
    typedef enum logic [3:0] {
        CMD_NOP,
        CMD_LOAD,
        CMD_DISPATCH,
        CMD_UPD_CHK,
        CMD_UPD_LD,
        CMD_RM_LD,
        CMD_DN_RD,
        CMD_DN_CMP,
        CMD_UP_RD,
        CMD_UP_CMP,
        CMD_FIN,
        CMD_RESULT
    } cmd_e;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] op;
        logic       full;
        logic       empty;
        logic       one_left;
        logic       tag_absent;
        logic       at_root;
        logic       up_better;
        logic       dn_end;
        logic       dn_better;
        logic       rsp_free;
    } dp_stat_t;

    // True when key a must sit above key b in the current order.
    function automatic logic better(input logic max_order, input key_t a, input key_t b);
        better = max_order ? (a > b) : (a < b);
    endfunction

endpackage

>>> hw/rtl/ibhq_ctrl.sv
// ----------------------------------------------------------------------------
// Indexed binary heap queue controller
// Sequences one operation at a time through the datapath.
// ----------------------------------------------------------------------------
module ibhq_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  ibhq_pkg::dp_stat_t stat,
    output ibhq_pkg::cmd_e     cmd
);

    typedef enum logic [10:0] {
        S_IDLE   = 11'b00000000001,
        S_DISP   = 11'b00000000010,
        S_BRANCH = 11'b00000000100,
        S_RM_LD  = 11'b00000001000,
        S_UPD_LD = 11'b00000010000,
        S_DN_RD  = 11'b00000100000,
        S_DN_CMP = 11'b00001000000,
        S_UP_RD  = 11'b00010000000,
        S_UP_CMP = 11'b00100000000,
        S_FIN    = 11'b01000000000,
        S_DONE   = 11'b10000000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   is_remove;

    assign is_remove = (stat.op == ibhq_pkg::OP_REMOVE);
    assign req_ready = (state_reg == S_IDLE);

    // Next state and command.
    always_comb
    begin
        state_next = state_reg;
        cmd        = ibhq_pkg::CMD_NOP;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd        = ibhq_pkg::CMD_LOAD;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                cmd        = ibhq_pkg::CMD_DISPATCH;
                state_next = S_BRANCH;
            end
            S_BRANCH:
            begin
                case (stat.op)
                    ibhq_pkg::OP_INSERT: state_next = stat.full ? S_DONE : S_UP_RD;
                    ibhq_pkg::OP_REMOVE: state_next = stat.empty ? S_DONE : S_RM_LD;
                    ibhq_pkg::OP_UPDATE:
                    begin
                        cmd        = ibhq_pkg::CMD_UPD_CHK;
                        state_next = stat.tag_absent ? S_DONE : S_UPD_LD;
                    end
                    default: state_next = S_DONE;
                endcase
            end
            S_RM_LD:
            begin
                cmd        = ibhq_pkg::CMD_RM_LD;
                state_next = stat.one_left ? S_DONE : S_DN_RD;
            end
            S_UPD_LD:
            begin
                cmd        = ibhq_pkg::CMD_UPD_LD;
                state_next = S_DN_RD;
            end
            S_DN_RD:
            begin
                cmd = ibhq_pkg::CMD_DN_RD;
                if (!stat.dn_end)
                    state_next = S_DN_CMP;
                else
                    state_next = is_remove ? S_FIN : S_UP_RD;
            end
            S_DN_CMP:
            begin
                cmd = ibhq_pkg::CMD_DN_CMP;
                if (stat.dn_better)
                    state_next = S_DN_RD;
                else
                    state_next = is_remove ? S_FIN : S_UP_RD;
            end
            S_UP_RD:
            begin
                cmd        = ibhq_pkg::CMD_UP_RD;
                state_next = stat.at_root ? S_FIN : S_UP_CMP;
            end
            S_UP_CMP:
            begin
                cmd        = ibhq_pkg::CMD_UP_CMP;
                state_next = stat.up_better ? S_UP_RD : S_FIN;
            end
            S_FIN:
            begin
                cmd        = ibhq_pkg::CMD_FIN;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (stat.rsp_free)
                begin
                    cmd        = ibhq_pkg::CMD_RESULT;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

>>> hw/rtl/ibhq_dp.sv
// ----------------------------------------------------------------------------
// Indexed binary heap queue datapath
// Slot memory, position table, working registers and the result register.
// ----------------------------------------------------------------------------
module ibhq_dp #(
    parameter int CAPACITY = ibhq_pkg::CAPACITY
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  ibhq_pkg::req_t     req,
    input  logic               cfg_we,
    input  logic               cfg_data,
    input  ibhq_pkg::cmd_e     cmd,
    output ibhq_pkg::dp_stat_t stat,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output ibhq_pkg::rsp_t     rsp
);

    localparam int PW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);
    localparam int TC = ibhq_pkg::TAG_COUNT;

    // Slot number (1-based) to memory address.
    function automatic logic [AW-1:0] slot_addr(input logic [PW:0] s);
        logic [PW:0] d;
        d = s - 1'b1;
        return d[AW-1:0];
    endfunction

    ibhq_pkg::entry_t  mem [CAPACITY];
    logic [PW-1:0]     posmem [TC];
    logic [TC-1:0]     ptv_reg;

    logic              max_order_reg;
    logic [1:0]        op_reg;
    ibhq_pkg::key_t    cur_key_reg;
    logic [31:0]       cur_pay_reg;
    ibhq_pkg::tag_t    cur_tag_reg;
    logic [PW-1:0]     pos_reg;
    logic [PW-1:0]     count_reg;
    logic [PW-1:0]     posrd_reg;
    logic              ptvrd_reg;
    ibhq_pkg::entry_t  rda_reg;
    ibhq_pkg::entry_t  rdb_reg;
    logic [1:0]        res_status_reg;
    ibhq_pkg::key_t    res_key_reg;
    logic [31:0]       res_pay_reg;
    ibhq_pkg::tag_t    res_tag_reg;
    logic [PW-1:0]     fpos_reg;
    ibhq_pkg::rsp_t    rsp_reg;
    logic              rsp_valid_reg;

    logic [PW:0]       cnt_w;
    logic [PW:0]       l_idx;
    logic [PW:0]       r_idx;
    logic [PW-1:0]     parent;
    logic              pick_r;
    ibhq_pkg::entry_t  child;
    logic [PW:0]       c_idx;
    logic              dn_better;
    logic              up_better;
    logic              tag_absent;
    logic              rd_en;
    logic [AW-1:0]     raddr_a;
    logic [AW-1:0]     raddr_b;
    logic              we;
    ibhq_pkg::entry_t  wdata;
    logic              pw_en;
    ibhq_pkg::tag_t    pw_idx;
    logic [PW-1:0]     pw_data;

    // Child and parent slots, and the comparisons that drive each step.
    assign cnt_w      = {1'b0, count_reg};
    assign l_idx      = {pos_reg, 1'b0};
    assign r_idx      = l_idx + 1'b1;
    assign parent     = pos_reg >> 1;
    assign pick_r     = (r_idx <= cnt_w) &&
                        !ibhq_pkg::better(max_order_reg, rda_reg.key, rdb_reg.key);
    assign child      = pick_r ? rdb_reg : rda_reg;
    assign c_idx      = pick_r ? r_idx : l_idx;
    assign dn_better  = ibhq_pkg::better(max_order_reg, child.key, cur_key_reg);
    assign up_better  = ibhq_pkg::better(max_order_reg, cur_key_reg, rda_reg.key);
    assign tag_absent = !ptvrd_reg || (posrd_reg == '0) || (posrd_reg > count_reg);

    assign stat.op         = op_reg;
    assign stat.full       = (count_reg >= PW'(CAPACITY));
    assign stat.empty      = (count_reg == '0);
    assign stat.one_left   = (count_reg == PW'(1));
    assign stat.tag_absent = tag_absent;
    assign stat.at_root    = (pos_reg == PW'(1));
    assign stat.up_better  = up_better;
    assign stat.dn_end     = (l_idx > cnt_w);
    assign stat.dn_better  = dn_better;
    assign stat.rsp_free   = !rsp_valid_reg || rsp_ready;

    // Read addresses for the two slot memory ports; the read registers only
    // load on a read command, so a fetched word stays put until it is used.
    always_comb
    begin
        rd_en   = 1'b0;
        raddr_a = '0;
        raddr_b = '0;
        case (cmd)
            ibhq_pkg::CMD_DISPATCH:
            begin
                rd_en   = 1'b1;
                raddr_a = slot_addr((PW+1)'(1));
                raddr_b = slot_addr(cnt_w);
            end
            ibhq_pkg::CMD_UPD_CHK:
            begin
                rd_en   = 1'b1;
                raddr_a = slot_addr({1'b0, posrd_reg});
            end
            ibhq_pkg::CMD_DN_RD:
            begin
                rd_en   = 1'b1;
                raddr_a = slot_addr(l_idx);
                raddr_b = slot_addr(r_idx);
            end
            ibhq_pkg::CMD_UP_RD:
            begin
                rd_en   = 1'b1;
                raddr_a = slot_addr({1'b0, parent});
            end
            default: raddr_a = '0;
        endcase
    end

    // Slot and position table writes.
    always_comb
    begin
        we      = 1'b0;
        wdata   = child;
        pw_en   = 1'b0;
        pw_idx  = child.tag;
        pw_data = pos_reg;
        case (cmd)
            ibhq_pkg::CMD_DN_CMP:
            begin
                we    = dn_better;
                pw_en = dn_better;
            end
            ibhq_pkg::CMD_UP_CMP:
            begin
                we     = up_better;
                wdata  = rda_reg;
                pw_en  = up_better;
                pw_idx = rda_reg.tag;
            end
            ibhq_pkg::CMD_FIN:
            begin
                we     = 1'b1;
                wdata  = '{key: cur_key_reg, payload: cur_pay_reg, tag: cur_tag_reg};
                pw_en  = 1'b1;
                pw_idx = cur_tag_reg;
            end
            ibhq_pkg::CMD_RM_LD:
            begin
                pw_en   = 1'b1;
                pw_idx  = rda_reg.tag;
                pw_data = '0;
            end
            default: we = 1'b0;
        endcase
    end

    // Slot memory: one write port, two registered read ports.
    always_ff @(posedge clk)
    begin
        if (we)
            mem[slot_addr({1'b0, pos_reg})] <= wdata;
        if (rd_en)
        begin
            rda_reg <= mem[raddr_a];
            rdb_reg <= mem[raddr_b];
        end
    end

    // Position table memory with registered read of the current tag.
    always_ff @(posedge clk)
    begin
        if (pw_en)
            posmem[pw_idx] <= pw_data;
        posrd_reg <= posmem[cur_tag_reg];
        ptvrd_reg <= ptv_reg[cur_tag_reg];
    end

    // Control registers: order, fill count, table valid bits, result valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_order_reg <= 1'b0;
            count_reg     <= '0;
            ptv_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                max_order_reg <= cfg_data;
            if (pw_en)
                ptv_reg[pw_idx] <= 1'b1;
            if (cmd == ibhq_pkg::CMD_RM_LD)
                count_reg <= count_reg - 1'b1;
            else if (cmd == ibhq_pkg::CMD_FIN && op_reg == ibhq_pkg::OP_INSERT)
                count_reg <= count_reg + 1'b1;
            if (cmd == ibhq_pkg::CMD_RESULT)
                rsp_valid_reg <= 1'b1;
            else if (rsp_ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    // Working registers of the operation in hand.
    always_ff @(posedge clk)
    begin
        case (cmd)
            ibhq_pkg::CMD_LOAD:
            begin
                op_reg         <= req.op;
                cur_key_reg    <= req.key;
                cur_pay_reg    <= req.payload;
                cur_tag_reg    <= req.tag;
                res_status_reg <= ibhq_pkg::ST_OK;
                res_key_reg    <= '0;
                res_pay_reg    <= '0;
                res_tag_reg    <= '0;
                fpos_reg       <= '0;
            end
            ibhq_pkg::CMD_DISPATCH:
            begin
                pos_reg <= count_reg + 1'b1;
                if (op_reg == ibhq_pkg::OP_INSERT && stat.full)
                    res_status_reg <= ibhq_pkg::ST_FULL;
                else if (op_reg == ibhq_pkg::OP_REMOVE && stat.empty)
                    res_status_reg <= ibhq_pkg::ST_EMPTY;
            end
            ibhq_pkg::CMD_UPD_CHK:
            begin
                pos_reg <= posrd_reg;
                if (tag_absent)
                    res_status_reg <= ibhq_pkg::ST_NOTAG;
            end
            ibhq_pkg::CMD_UPD_LD:
            begin
                cur_pay_reg <= rda_reg.payload;
                cur_tag_reg <= rda_reg.tag;
            end
            ibhq_pkg::CMD_RM_LD:
            begin
                res_key_reg <= rda_reg.key;
                res_pay_reg <= rda_reg.payload;
                res_tag_reg <= rda_reg.tag;
                cur_key_reg <= rdb_reg.key;
                cur_pay_reg <= rdb_reg.payload;
                cur_tag_reg <= rdb_reg.tag;
                pos_reg     <= PW'(1);
            end
            ibhq_pkg::CMD_DN_CMP:
            begin
                if (dn_better)
                    pos_reg <= c_idx[PW-1:0];
            end
            ibhq_pkg::CMD_UP_CMP:
            begin
                if (up_better)
                    pos_reg <= parent;
            end
            ibhq_pkg::CMD_FIN:
            begin
                if (op_reg != ibhq_pkg::OP_REMOVE)
                    fpos_reg <= pos_reg;
            end
            ibhq_pkg::CMD_RESULT:
            begin
                rsp_reg.status         <= res_status_reg;
                rsp_reg.out_key        <= res_key_reg;
                rsp_reg.out_payload    <= res_pay_reg;
                rsp_reg.out_tag        <= res_tag_reg;
                rsp_reg.final_position <= ibhq_pkg::pos_t'(fpos_reg);
                rsp_reg.fill_count     <= ibhq_pkg::pos_t'(count_reg);
            end
            default: pos_reg <= pos_reg;
        endcase
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

>>> hw/rtl/indexed_binary_heap_queue.sv
// ----------------------------------------------------------------------------
// Indexed binary heap queue
// Priority queue of signed keys with payloads and tags, min or max order.
// ----------------------------------------------------------------------------
// A request word (op, key, payload, tag) is taken on req_valid and req_ready;
// every request gives exactly one result word on rsp_valid and rsp_ready.
// Operations: insert, remove root, and update of the key of a tagged entry.
// cfg_we writes cfg_data into the order bit (0 smallest root, 1 largest root);
// write it only while the block is idle.
// One operation is in hand at a time. Each heap level crossed takes a
// registered slot memory read, then a compare and move, and a final step
// writes the entry into its place. Insert sifts up, remove sifts down and
// skips the sift when it empties the heap, update sifts down and then up,
// and a failed operation goes straight to its result. At 64 slots an
// operation crosses at most 6 heap levels. The next request can be taken
// in the same cycle as the result is presented; if the receiver stalls, the
// next operation finishes and then waits for the output register to drain.
// Reset empties the heap, marks every tag absent and selects min order; no
// clearing pass is needed.
// ----------------------------------------------------------------------------
module indexed_binary_heap_queue #(
    parameter int CAPACITY = ibhq_pkg::CAPACITY
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  ibhq_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output ibhq_pkg::rsp_t rsp,
    input  logic           cfg_we,
    input  logic           cfg_data
);

    ibhq_pkg::cmd_e     cmd;
    ibhq_pkg::dp_stat_t stat;

    // Sequencer.
    ibhq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Storage and arithmetic.
    ibhq_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

>>> hw/rtl/ibhq_chk.sv
// ----------------------------------------------------------------------------
// Indexed binary heap queue checker
// Port-level assertions, attached to the top level by bind.
// ----------------------------------------------------------------------------
module ibhq_chk #(
    parameter int CAPACITY = ibhq_pkg::CAPACITY
)
(
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_ready,
    input logic           rsp_valid,
    input logic           rsp_ready,
    input ibhq_pkg::rsp_t rsp
);

    // A stalled result word holds.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("result word changed while stalled");

    // The fill count never exceeds the capacity.
    a_fill: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.fill_count <= ibhq_pkg::pos_t'(CAPACITY)))
        else $error("fill count beyond capacity");

    // A failed operation reports nothing but its status and the fill count.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status != ibhq_pkg::ST_OK) |->
            (rsp.final_position == '0) && (rsp.out_key == '0) &&
            (rsp.out_payload == '0) && (rsp.out_tag == '0))
        else $error("error result carries data");

    // A landing slot always lies inside the filled part of the heap.
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.final_position <= rsp.fill_count))
        else $error("final position beyond fill count");

    // A request is never taken in the cycle straight after another.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while one is in hand");

endmodule

bind indexed_binary_heap_queue ibhq_chk #(
    .CAPACITY (CAPACITY)
) u_ibhq_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);
